// ===== src/afp_pkg.sv =====
`default_nettype none

package afp_pkg;

    // Fixed geometry of the map and plane
    localparam int MAP_SIDE   = 128;
    localparam int PLANE_SIDE = 1024;
    localparam int MEM_WORDS  = 16384;
    localparam int ADDR_W     = $clog2(MEM_WORDS);
    localparam int PLANE_W    = $clog2(PLANE_SIDE);
    localparam int MAP_W      = $clog2(MAP_SIDE);

    // Datapath widths
    localparam int COORD_W = 12;                 // lx / ly, signed
    localparam int PROD_W  = 16 + COORD_W;       // matrix element * coordinate
    localparam int SUM_W   = PROD_W + 1;         // two products plus centre
    localparam int POS_W   = SUM_W - 8;          // plane position after floor(/256)
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    // Commands
    localparam logic CMD_RENDER = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATRIX_A = 3'd0,
        CFG_MATRIX_B = 3'd1,
        CFG_MATRIX_C = 3'd2,
        CFG_MATRIX_D = 3'd3,
        CFG_CENTER_X = 3'd4,
        CFG_CENTER_Y = 3'd5,
        CFG_SCROLL   = 3'd6,
        CFG_REPEAT   = 3'd7
    } t_cfg_index;

    // Behaviour outside the plane
    typedef enum logic [1:0] {
        REP_WRAP_A      = 2'd0,
        REP_WRAP_B      = 2'd1,
        REP_TRANSPARENT = 2'd2,
        REP_TILE_ZERO   = 2'd3
    } t_repeat;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] word_address;
        logic [7:0]        map_byte;
        logic [7:0]        char_byte;
        logic [7:0]        screen_column;
        logic [7:0]        screen_line;
        logic              second_layer;
    } t_in_item;

    typedef struct packed {
        logic [7:0] color_index;
        logic       high_priority;
        logic       opaque;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] matrix_a;
        logic signed [15:0] matrix_b;
        logic signed [15:0] matrix_c;
        logic signed [15:0] matrix_d;
        logic signed [12:0] center_x;
        logic signed [12:0] center_y;
        logic [25:0]        scroll_offsets;
        t_repeat            repeat_mode;
    } t_cfg;

    // Per-item control that travels alongside the datapath
    typedef struct packed {
        logic              valid;
        logic              command;
        logic              second_layer;
        logic [ADDR_W-1:0] word_address;
        logic [7:0]        map_byte;
        logic [7:0]        char_byte;
    } t_tag;

endpackage

`default_nettype wire

// ===== src/afp_transform.sv =====
`default_nettype none

// Affine transform: offset/clip, four multiplies, sum and floor.
// Three register stages.
module afp_transform (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  afp_pkg::t_in_item                 i_item,
    input  afp_pkg::t_cfg                     i_cfg,
    output afp_pkg::t_tag                     o_tag,
    output logic signed [afp_pkg::POS_W-1:0]  o_px,
    output logic signed [afp_pkg::POS_W-1:0]  o_py
);
    import afp_pkg::*;

    logic signed [13:0]        w_h;
    logic signed [13:0]        w_v;
    logic signed [10:0]        w_hclip;
    logic signed [10:0]        w_vclip;
    logic signed [COORD_W-1:0] n_lx;
    logic signed [COORD_W-1:0] n_ly;
    t_tag                      n_tag1;

    t_tag                      r_tag1;
    t_tag                      r_tag2;
    t_tag                      r_tag3;
    logic signed [COORD_W-1:0] r_lx;
    logic signed [COORD_W-1:0] r_ly;
    logic signed [15:0]        w_a;
    logic signed [15:0]        w_b;
    logic signed [15:0]        w_c;
    logic signed [15:0]        w_d;
    logic signed [PROD_W-1:0]  r_pa;
    logic signed [PROD_W-1:0]  r_pb;
    logic signed [PROD_W-1:0]  r_pc;
    logic signed [PROD_W-1:0]  r_pd;
    logic signed [SUM_W-1:0]   w_cx8;
    logic signed [SUM_W-1:0]   w_cy8;
    logic signed [SUM_W-1:0]   n_sx;
    logic signed [SUM_W-1:0]   n_sy;
    logic signed [POS_W-1:0]   r_px;
    logic signed [POS_W-1:0]   r_py;

    // Stage 1: scroll minus centre, clipped to 11-bit signed, plus screen position
    always_comb begin
        w_h = {i_cfg.scroll_offsets[12], i_cfg.scroll_offsets[12:0]}
            - {i_cfg.center_x[12], i_cfg.center_x};
        w_v = {i_cfg.scroll_offsets[25], i_cfg.scroll_offsets[25:13]}
            - {i_cfg.center_y[12], i_cfg.center_y};
        // keep low 10 bits, bit 13 acts as the sign
        w_hclip = {w_h[13], w_h[9:0]};
        w_vclip = {w_v[13], w_v[9:0]};
        n_lx = {w_hclip[10], w_hclip} + {4'b0, i_item.screen_column};
        n_ly = {w_vclip[10], w_vclip} + {4'b0, i_item.screen_line};
        n_tag1.valid        = i_valid;
        n_tag1.command      = i_item.command;
        n_tag1.second_layer = i_item.second_layer;
        n_tag1.word_address = i_item.word_address;
        n_tag1.map_byte     = i_item.map_byte;
        n_tag1.char_byte    = i_item.char_byte;
    end

    // Stage 3 inputs: centre scaled by 256, products summed
    always_comb begin
        w_a   = i_cfg.matrix_a;
        w_b   = i_cfg.matrix_b;
        w_c   = i_cfg.matrix_c;
        w_d   = i_cfg.matrix_d;
        w_cx8 = {{(SUM_W-21){i_cfg.center_x[12]}}, i_cfg.center_x, 8'b0};
        w_cy8 = {{(SUM_W-21){i_cfg.center_y[12]}}, i_cfg.center_y, 8'b0};
        n_sx  = {r_pa[PROD_W-1], r_pa} + {r_pb[PROD_W-1], r_pb} + w_cx8;
        n_sy  = {r_pc[PROD_W-1], r_pc} + {r_pd[PROD_W-1], r_pd} + w_cy8;
    end

    // Control tags and datapath registers; only the valid bits are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
        end else if (i_en) begin
            r_tag1 <= n_tag1;
            r_lx   <= n_lx;
            r_ly   <= n_ly;

            r_tag2 <= r_tag1;
            r_pa   <= w_a * r_lx;
            r_pb   <= w_b * r_ly;
            r_pc   <= w_c * r_lx;
            r_pd   <= w_d * r_ly;

            r_tag3 <= r_tag2;
            // floor(/256) of a two's complement value is an arithmetic shift
            r_px   <= n_sx[SUM_W-1:8];
            r_py   <= n_sy[SUM_W-1:8];
        end
    end

    assign o_tag = r_tag3;
    assign o_px  = r_px;
    assign o_py  = r_py;

endmodule

`default_nettype wire

// ===== src/afp_fetch.sv =====
`default_nettype none

// Tile and texel lookup: tile map read, then texel read, then formatting.
// Writes land in each memory at the same stage as that memory's reads,
// so accesses stay in item order.
module afp_fetch (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  afp_pkg::t_tag                     i_tag,
    input  logic signed [afp_pkg::POS_W-1:0]  i_px,
    input  logic signed [afp_pkg::POS_W-1:0]  i_py,
    input  afp_pkg::t_repeat                  i_mode,
    output logic                              o_valid,
    output afp_pkg::t_out_item                o_item
);
    import afp_pkg::*;

    logic [7:0] tile_map    [MEM_WORDS];
    logic [7:0] texel_store [MEM_WORDS];

    logic              w_outside;
    logic              w_transp;
    logic              w_zero;
    logic [ADDR_W-1:0] w_map_addr;
    logic [5:0]        w_sub;
    logic [ADDR_W-1:0] w_texel_addr;
    logic [7:0]        w_texel;

    t_tag              r_tag4;
    t_tag              r_tag5;
    logic              r_transp4;
    logic              r_transp5;
    logic [5:0]        r_sub4;
    logic [7:0]        r_tile;
    logic [7:0]        r_texel;

    // Plane bounds and tile map address
    always_comb begin
        w_outside = (|i_px[POS_W-1:PLANE_W]) || (|i_py[POS_W-1:PLANE_W]);
        w_transp  = (i_mode == REP_TRANSPARENT) && w_outside;
        w_zero    = (i_mode == REP_TILE_ZERO) && w_outside;
        w_map_addr = w_zero ? '0
                            : {i_py[PLANE_W-1:3], i_px[PLANE_W-1:3]};
        w_sub     = {i_py[2:0], i_px[2:0]};
    end

    // Stage 4: tile map port
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_tag.valid && i_tag.command == CMD_WRITE) begin
                tile_map[i_tag.word_address] <= i_tag.map_byte;
            end
            r_tile <= tile_map[w_map_addr];
        end
    end

    assign w_texel_addr = {r_tile, r_sub4};

    // Stage 5: texel store port
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_tag4.valid && r_tag4.command == CMD_WRITE) begin
                texel_store[r_tag4.word_address] <= r_tag4.char_byte;
            end
            r_texel <= texel_store[w_texel_addr];
        end
    end

    // Tags and side data; only the valid bits are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag4.valid <= 1'b0;
            r_tag5.valid <= 1'b0;
        end else if (i_en) begin
            r_tag4    <= i_tag;
            r_transp4 <= w_transp;
            r_sub4    <= w_sub;

            r_tag5    <= r_tag4;
            r_transp5 <= r_transp4;
        end
    end

    // Result formatting: writes and transparent pixels give zero
    always_comb begin
        w_texel = (r_tag5.command == CMD_WRITE || r_transp5) ? 8'd0 : r_texel;
        if (r_tag5.second_layer) begin
            o_item.high_priority = w_texel[7];
            o_item.color_index   = {1'b0, w_texel[6:0]};
        end else begin
            o_item.high_priority = 1'b0;
            o_item.color_index   = w_texel;
        end
        o_item.opaque = |o_item.color_index;
    end

    assign o_valid = r_tag5.valid;

endmodule

`default_nettype wire

// ===== src/affine_tilemap_pixel_fetch.sv =====
// Affine tile-map background sampler. One item per clock while the skid stage
// is free: a render item (screen column and line) returns one texel, a write
// item stores a tile-map byte and a texel byte at one word and returns an
// all-zero result. Every item gives exactly one result, in order. It passes
// through three transform stages (clip and offset, multiply, sum and floor)
// and two memory stages (tile map read, texel read); the output register plus
// a one-entry skid stage keep the input open while a result waits. Both
// memories are undefined until written. The user must write registers on the
// plain write port only while no item is in flight; the block does not check.
`default_nettype none

module affine_tilemap_pixel_fetch (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  afp_pkg::t_in_item                     i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output afp_pkg::t_out_item                    o_out,
    input  logic                                  i_cfg_we,
    input  logic [afp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [afp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import afp_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_en;
    t_tag                 w_tag3;
    logic signed [POS_W-1:0] w_px;
    logic signed [POS_W-1:0] w_py;
    logic                 w_res_valid;
    t_out_item            w_res;
    logic                 r_out_valid;
    t_out_item            r_out;
    logic                 r_skid_valid;
    t_out_item            r_skid;

    // Pipeline moves whenever the skid stage is free
    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MATRIX_A: r_cfg.matrix_a       <= i_cfg_data[15:0];
                CFG_MATRIX_B: r_cfg.matrix_b       <= i_cfg_data[15:0];
                CFG_MATRIX_C: r_cfg.matrix_c       <= i_cfg_data[15:0];
                CFG_MATRIX_D: r_cfg.matrix_d       <= i_cfg_data[15:0];
                CFG_CENTER_X: r_cfg.center_x       <= i_cfg_data[12:0];
                CFG_CENTER_Y: r_cfg.center_y       <= i_cfg_data[12:0];
                CFG_SCROLL:   r_cfg.scroll_offsets <= i_cfg_data[25:0];
                CFG_REPEAT:   r_cfg.repeat_mode    <= t_repeat'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    afp_transform u_transform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in),
        .i_cfg   (r_cfg),
        .o_tag   (w_tag3),
        .o_px    (w_px),
        .o_py    (w_py)
    );

    afp_fetch u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag3),
        .i_px    (w_px),
        .i_py    (w_py),
        .i_mode  (r_cfg.repeat_mode),
        .o_valid (w_res_valid),
        .o_item  (w_res)
    );

    // Output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_en && w_res_valid;
            end
        end else if (w_en && w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_en && w_res_valid) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== src/afp_checker.sv =====
`default_nettype none

module afp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input afp_pkg::t_out_item             o_out
);
    import afp_pkg::*;

    // A result waiting for transfer holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Opaque flag follows the colour
    a_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.opaque == (o_out.color_index != 8'd0))
        else $error("opaque flag does not match colour");

    // Reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset leaves the input open
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind affine_tilemap_pixel_fetch afp_checker u_afp_checker (.*);

`default_nettype wire
